@@ hw/rtl/cdrt_pkg.sv @@
`timescale 1ns / 1ps

package cdrt_pkg;

    localparam int CELLS_PER_SIDE = 32;
    localparam int GRID_COLS      = 8;
    localparam int GRID_ROWS      = 8;
    localparam int NUM_CHUNKS     = GRID_COLS * GRID_ROWS;

    localparam int FIELD_W = 5;
    localparam int CHUNK_W = 3;
    localparam int PAD_W   = 3;
    localparam int CNT_W   = 16;
    localparam int CELL_W  = $clog2(CELLS_PER_SIDE);
    localparam int IDX_W   = $clog2(NUM_CHUNKS);
    localparam int NUM_TGT = 4;

    localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELLS_PER_SIDE - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
    localparam logic [PAD_W-1:0]  PAD_RESET = PAD_W'(3);

    typedef enum logic
    {
        OP_MARK = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic
    {
        S_IDLE   = 1'b0,
        S_UPDATE = 1'b1
    } state_t;

    typedef struct packed
    {
        logic [CELL_W-1:0] min_c;
        logic [CELL_W-1:0] max_c;
        logic [CELL_W-1:0] min_r;
        logic [CELL_W-1:0] max_r;
    } box_t;

    typedef struct packed
    {
        box_t             box;
        logic [CNT_W-1:0] count;
    } entry_t;

    // one chunk update: own chunk in slot 0, neighbours packed behind it
    typedef struct packed
    {
        logic             en;
        logic             bump;
        logic [IDX_W-1:0] idx;
        box_t             box;
    } tgt_t;

    localparam box_t EMPTY_BOX = '{
        min_c: CELL_LAST,
        max_c: '0,
        min_r: CELL_LAST,
        max_r: '0
    };

endpackage

@@ hw/rtl/cdrt_ram.sv @@
`timescale 1ns / 1ps

module cdrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/cdrt_plan.sv @@
`timescale 1ns / 1ps

module cdrt_plan (
    input  logic                        operation,
    input  logic [cdrt_pkg::CHUNK_W-1:0] chunk_col,
    input  logic [cdrt_pkg::CHUNK_W-1:0] chunk_row,
    input  logic [cdrt_pkg::FIELD_W-1:0] cell_col,
    input  logic [cdrt_pkg::FIELD_W-1:0] cell_row,
    input  logic [cdrt_pkg::PAD_W-1:0]   pad,
    output cdrt_pkg::tgt_t [cdrt_pkg::NUM_TGT-1:0] tgts
);

    import cdrt_pkg::*;

    localparam int SW = ((CELL_W > PAD_W) ? CELL_W : PAD_W) + 2;
    localparam logic signed [SW-1:0] LAST_S = SW'(CELLS_PER_SIDE - 1);

    function automatic logic [CELL_W-1:0] clamp_cell(input logic signed [SW-1:0] v);
        logic [CELL_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > LAST_S)
        begin
            r = CELL_LAST;
        end
        else
        begin
            r = CELL_W'(v);
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] chunk_index(input int col, input int row);
        return IDX_W'(row * GRID_COLS + col);
    endfunction

    logic [CELL_W-1:0]        cx, cy;
    logic signed [SW-1:0]     lo_c, hi_c, lo_r, hi_r;
    logic                     left, right, up, down;
    logic                     in_grid, is_mark;
    logic                     h_en, v_en, d_en;
    int                       ncol, nrow;
    box_t                     own_box, h_box, v_box, d_box;
    logic [IDX_W-1:0]         own_idx, h_idx, v_idx, d_idx;
    logic [CELL_W-1:0]        sc_min, sc_max, sr_min, sr_max;

    always_comb
    begin
        cx = (int'(cell_col) > CELLS_PER_SIDE - 1) ? CELL_LAST : CELL_W'(cell_col);
        cy = (int'(cell_row) > CELLS_PER_SIDE - 1) ? CELL_LAST : CELL_W'(cell_row);

        lo_c = signed'(SW'(cx)) - signed'(SW'(pad));
        hi_c = signed'(SW'(cx)) + signed'(SW'(pad));
        lo_r = signed'(SW'(cy)) - signed'(SW'(pad));
        hi_r = signed'(SW'(cy)) + signed'(SW'(pad));

        own_box.min_c = clamp_cell(lo_c);
        own_box.max_c = clamp_cell(hi_c);
        own_box.min_r = clamp_cell(lo_r);
        own_box.max_r = clamp_cell(hi_r);

        // left/top spill wins when both sides spill
        left  = lo_c < 0;
        right = !left && (hi_c > LAST_S);
        up    = lo_r < 0;
        down  = !up && (hi_r > LAST_S);

        sc_min = left ? clamp_cell(LAST_S + lo_c) : '0;
        sc_max = left ? CELL_LAST : clamp_cell(hi_c - LAST_S);
        sr_min = up ? clamp_cell(LAST_S + lo_r) : '0;
        sr_max = up ? CELL_LAST : clamp_cell(hi_r - LAST_S);

        in_grid = (int'(chunk_col) < GRID_COLS) && (int'(chunk_row) < GRID_ROWS);
        is_mark = op_t'(operation) == OP_MARK;

        ncol = left ? int'(chunk_col) - 1 : int'(chunk_col) + 1;
        nrow = up ? int'(chunk_row) - 1 : int'(chunk_row) + 1;

        h_en = is_mark && in_grid &&
               ((left && chunk_col != '0) || (right && ncol < GRID_COLS));
        v_en = is_mark && in_grid &&
               ((up && chunk_row != '0) || (down && nrow < GRID_ROWS));
        d_en = h_en && v_en;

        own_idx = chunk_index(int'(chunk_col), int'(chunk_row));
        h_idx   = chunk_index(ncol, int'(chunk_row));
        v_idx   = chunk_index(int'(chunk_col), nrow);
        d_idx   = chunk_index(ncol, nrow);

        h_box = '{min_c: sc_min, max_c: sc_max, min_r: own_box.min_r, max_r: own_box.max_r};
        v_box = '{min_c: own_box.min_c, max_c: own_box.max_c, min_r: sr_min, max_r: sr_max};
        d_box = '{min_c: sc_min, max_c: sc_max, min_r: sr_min, max_r: sr_max};

        // diagonal implies both others, so the list stays contiguous
        tgts[0] = '{en: in_grid, bump: is_mark, idx: own_idx, box: own_box};
        if (h_en)
        begin
            tgts[1] = '{en: 1'b1, bump: 1'b0, idx: h_idx, box: h_box};
        end
        else
        begin
            tgts[1] = '{en: v_en, bump: 1'b0, idx: v_idx, box: v_box};
        end
        tgts[2] = '{en: d_en, bump: 1'b0, idx: v_idx, box: v_box};
        tgts[3] = '{en: d_en, bump: 1'b0, idx: d_idx, box: d_box};
    end

endmodule

@@ hw/rtl/chunk_dirty_rect_tracker.sv @@
`timescale 1ns / 1ps

// Dirty-box tracker for an 8 x 8 grid of 32 x 32-cell chunks. An item is taken
// when start is high and busy is low. In the S_UPDATE state a mark does one
// read-modify-write through the single state RAM for each chunk it touches (own
// chunk plus up to three neighbours, 1 to 4); a read-and-clear reads and clears
// its own chunk. The result of a read-and-clear is registered from the S_UPDATE
// state and driven on the box and count ports with done high for one cycle, and
// is taken at the edge that ends that cycle; it must be captured then, as the
// block does not wait for the receiver. Marks give no result. The pad (pad_reg)
// is written through cfg_valid/cfg_data (always ready) and should only change
// while busy is low. No clearing pass is needed after reset: per-chunk valid
// flags make unwritten chunks read as empty.
module chunk_dirty_rect_tracker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         operation,
    input  logic [cdrt_pkg::CHUNK_W-1:0] chunk_col,
    input  logic [cdrt_pkg::CHUNK_W-1:0] chunk_row,
    input  logic [cdrt_pkg::FIELD_W-1:0] cell_col,
    input  logic [cdrt_pkg::FIELD_W-1:0] cell_row,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cdrt_pkg::PAD_W-1:0]   cfg_data,
    output logic                         done,
    output logic [cdrt_pkg::FIELD_W-1:0] box_min_col,
    output logic [cdrt_pkg::FIELD_W-1:0] box_max_col,
    output logic [cdrt_pkg::FIELD_W-1:0] box_min_row,
    output logic [cdrt_pkg::FIELD_W-1:0] box_max_row,
    output logic                         box_empty,
    output logic [cdrt_pkg::CNT_W-1:0]   event_count
);

    import cdrt_pkg::*;

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    tgt_t [NUM_TGT-1:0]     tgt_reg, tgt_next, plan_tgts;
    logic [NUM_CHUNKS-1:0]  valid_reg, valid_next;
    logic [PAD_W-1:0]       pad_reg, pad_next;
    logic                   done_reg, done_next;
    box_t                   obox_reg, obox_next;
    logic                   oempty_reg, oempty_next;
    logic [CNT_W-1:0]       ocnt_reg, ocnt_next;

    logic                   accept;
    logic                   ram_we, ram_re;
    logic [IDX_W-1:0]       ram_waddr, ram_raddr;
    entry_t                 ram_wdata, ram_rdata;
    entry_t                 old_entry, merged;
    tgt_t                   cur;
    logic                   hit;

    cdrt_plan u_plan (
        .operation (operation),
        .chunk_col (chunk_col),
        .chunk_row (chunk_row),
        .cell_col  (cell_col),
        .cell_row  (cell_row),
        .pad       (pad_reg),
        .tgts      (plan_tgts)
    );

    cdrt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_CHUNKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy      = state_reg != S_IDLE;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // merge of the head target with what the RAM returned
    always_comb
    begin
        cur = tgt_reg[0];
        hit = cur.en && valid_reg[cur.idx];
        old_entry = hit ? ram_rdata : '{box: EMPTY_BOX, count: '0};

        merged.box.min_c = (cur.box.min_c < old_entry.box.min_c) ? cur.box.min_c
                                                                 : old_entry.box.min_c;
        merged.box.max_c = (cur.box.max_c > old_entry.box.max_c) ? cur.box.max_c
                                                                 : old_entry.box.max_c;
        merged.box.min_r = (cur.box.min_r < old_entry.box.min_r) ? cur.box.min_r
                                                                 : old_entry.box.min_r;
        merged.box.max_r = (cur.box.max_r > old_entry.box.max_r) ? cur.box.max_r
                                                                 : old_entry.box.max_r;
        if (cur.bump && old_entry.count != CNT_MAX)
        begin
            merged.count = old_entry.count + CNT_W'(1);
        end
        else
        begin
            merged.count = old_entry.count;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (!(op_reg == OP_MARK && tgt_reg[1].en))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        tgt_next    = tgt_reg;
        valid_next  = valid_reg;
        done_next   = 1'b0;
        obox_next   = obox_reg;
        oempty_next = oempty_reg;
        ocnt_next   = ocnt_reg;
        ram_we      = 1'b0;
        ram_waddr   = cur.idx;
        ram_wdata   = merged;
        ram_re      = 1'b0;
        ram_raddr   = plan_tgts[0].idx;
        pad_next    = (cfg_valid && cfg_ready) ? cfg_data : pad_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = op_t'(operation);
                    tgt_next = plan_tgts;
                    ram_re   = 1'b1;
                end
            end
            S_UPDATE:
            begin
                ram_raddr = tgt_reg[1].idx;
                ram_re    = tgt_reg[1].en;
                for (int i = 0; i < NUM_TGT - 1; i++)
                begin
                    tgt_next[i] = tgt_reg[i + 1];
                end
                tgt_next[NUM_TGT-1].en = 1'b0;

                if (op_reg == OP_READ)
                begin
                    done_next   = 1'b1;
                    obox_next   = old_entry.box;
                    oempty_next = !hit;
                    ocnt_next   = old_entry.count;
                    if (cur.en)
                    begin
                        valid_next[cur.idx] = 1'b0;
                    end
                end
                else if (cur.en)
                begin
                    ram_we              = 1'b1;
                    valid_next[cur.idx] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            pad_reg   <= PAD_RESET;
            done_reg  <= 1'b0;
            op_reg    <= OP_MARK;
            tgt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            pad_reg   <= pad_next;
            done_reg  <= done_next;
            op_reg    <= op_next;
            tgt_reg   <= tgt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obox_reg   <= obox_next;
        oempty_reg <= oempty_next;
        ocnt_reg   <= ocnt_next;
    end

    assign done        = done_reg;
    assign box_min_col = FIELD_W'(obox_reg.min_c);
    assign box_max_col = FIELD_W'(obox_reg.max_c);
    assign box_min_row = FIELD_W'(obox_reg.min_r);
    assign box_max_row = FIELD_W'(obox_reg.max_r);
    assign box_empty   = oempty_reg;
    assign event_count = ocnt_reg;

endmodule
